>>> sv/bcsv_pkg.sv
`default_nettype none

package bcsv_pkg;

  localparam int MAX_FRAME  = 128;
  localparam int NUM_FIELDS = 4;
  localparam int OUT_VALUES = 4;

  localparam int FLEN_W = 8;
  localparam int IDX_W  = $clog2(NUM_FIELDS + 1);
  localparam int CAP_IW = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
  localparam int CNT_W  = 3;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [OUT_VALUES-1:0][31:0] values;
    logic [CNT_W-1:0]            count;
  } res_t;

  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } buf_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // acc * 10 + d, clamped at the magnitude limit
  function automatic logic [31:0] acc_step(input logic [31:0] acc, input logic [3:0] d);
    logic [35:0] wide;
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, d};
    if (wide > {4'b0, MAG_LIMIT}) begin
      return MAG_LIMIT;
    end
    return wide[31:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/bcsv_res_buf.sv
`default_nettype none

module bcsv_res_buf
  import bcsv_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  res_t       push_data_i,
  input  wire        out_stall_i,
  output logic       out_valid_o,
  output res_t       out_data_o,
  output buf_stat_t  stat_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic fire;

  assign fire = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (!out_valid_q) begin
      out_valid_d = push_i;
      out_d       = push_data_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign stat_o.out_valid  = out_valid_q;
  assign stat_o.skid_valid = skid_valid_q;

endmodule

`default_nettype wire

>>> sv/bracketed_csv_integer_frame_parser_top.sv
// path: a closing ']' beat goes through the input register, then the parse logic into the
// result register, which raises out_valid_o
// throughput: one byte beat per cycle while results drain
// a two-entry result buffer (output register plus skid) holds results while out_stall_i
// is high; in_stall_o rises once the byte in flight plus results held past this edge reach two
// reset: rst_ni async active low, parser returns to hunting for '[' and buffers empty
`default_nettype none

module bracketed_csv_integer_frame_parser_top
  import bcsv_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  // byte channel
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [7:0]        rx_byte_i,
  // result channel
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic signed [31:0] value_0_o,
  output logic signed [31:0] value_1_o,
  output logic signed [31:0] value_2_o,
  output logic signed [31:0] value_3_o,
  output logic [2:0]        field_count_o
);

  // input register stage
  logic       byte_v_q;
  logic [7:0] byte_q;
  logic       in_fire;

  // parser state
  logic                  in_frame_q, in_frame_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  open_q, open_d;
  phase_e                phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [31:0]           acc_q, acc_d;
  logic [31:0]           cap_q [NUM_FIELDS];
  logic [31:0]           cap_d [NUM_FIELDS];
  logic [FLEN_W-1:0]     flen_q, flen_d;

  // token byte helpers
  phase_e      ph_eff;
  logic        neg_eff;
  logic [31:0] acc_eff;
  logic        is_digit;
  logic [3:0]  digit;
  logic [31:0] tok_val;

  // result path
  logic                        push;
  logic [OUT_VALUES-1:0][31:0] res_vals;
  res_t                        push_data;
  res_t                        out_data;
  buf_stat_t                   buf_stat;
  logic                        out_fire;
  logic [1:0]                  occ;

  // ---------------------------------------------------------------------------
  // input handshake: stall when the byte in flight plus buffered results would
  // leave no room for another result after this edge
  // ---------------------------------------------------------------------------
  assign out_fire   = out_valid_o & ~out_stall_i;
  assign occ        = 2'(byte_v_q) + 2'(buf_stat.out_valid) + 2'(buf_stat.skid_valid)
                      - 2'(out_fire);
  assign in_stall_o = (occ >= 2'd2);
  assign in_fire    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_v_q <= 1'b0;
    end else begin
      byte_v_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= rx_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // token byte decode; a token that is not yet open starts from a clean number
  // ---------------------------------------------------------------------------
  assign ph_eff   = open_q ? phase_q : PH_SPACE;
  assign neg_eff  = open_q ? neg_q : 1'b0;
  assign acc_eff  = open_q ? acc_q : 32'd0;
  assign is_digit = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign digit    = 4'(byte_q - CH_ZERO);

  // signed value of the open token, clamped to the 32-bit range
  assign tok_val = neg_q ? (32'd0 - acc_q) : (acc_q[31] ? 32'h7FFF_FFFF : acc_q);

  // ---------------------------------------------------------------------------
  // parser next state
  // ---------------------------------------------------------------------------
  always_comb begin
    in_frame_d = in_frame_q;
    idx_d      = idx_q;
    open_d     = open_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    acc_d      = acc_q;
    cap_d      = cap_q;
    flen_d     = flen_q;
    push       = 1'b0;
    if (byte_v_q) begin
      if (!in_frame_q) begin
        // hunting: only an opening bracket matters
        if (byte_q == CH_LBRACK) begin
          in_frame_d = 1'b1;
          idx_d      = '0;
          open_d     = 1'b0;
          phase_d    = PH_SPACE;
          neg_d      = 1'b0;
          acc_d      = '0;
          flen_d     = FLEN_W'(1);
          for (int i = 0; i < NUM_FIELDS; i++) begin
            cap_d[i] = '0;
          end
        end
      end else if (flen_q >= FLEN_W'(MAX_FRAME)) begin
        // overlong frame: drop it, this byte is swallowed
        in_frame_d = 1'b0;
        flen_d     = '0;
        open_d     = 1'b0;
      end else begin
        flen_d = flen_q + FLEN_W'(1);
        if (byte_q == CH_COMMA || byte_q == CH_RBRACK) begin
          // close the token; empty tokens leave no trace
          if (open_q && (idx_q < IDX_W'(NUM_FIELDS))) begin
            cap_d[idx_q[CAP_IW-1:0]] = tok_val;
            idx_d                    = idx_q + IDX_W'(1);
          end
          open_d = 1'b0;
          if (byte_q == CH_RBRACK) begin
            push       = 1'b1;
            in_frame_d = 1'b0;
            flen_d     = '0;
          end
        end else begin
          open_d  = 1'b1;
          phase_d = ph_eff;
          neg_d   = neg_eff;
          acc_d   = acc_eff;
          // tokens past the last field and finished numbers ignore content
          if ((idx_q < IDX_W'(NUM_FIELDS)) && (ph_eff != PH_DONE)) begin
            if (is_digit) begin
              acc_d   = acc_step(acc_eff, digit);
              phase_d = PH_DIGITS;
            end else if ((ph_eff == PH_SPACE) && is_space(byte_q)) begin
              phase_d = PH_SPACE;
            end else if ((ph_eff == PH_SPACE) &&
                         (byte_q == CH_PLUS || byte_q == CH_MINUS)) begin
              neg_d   = (byte_q == CH_MINUS);
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_DONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      idx_q      <= '0;
      open_q     <= 1'b0;
      phase_q    <= PH_SPACE;
      neg_q      <= 1'b0;
      acc_q      <= '0;
      flen_q     <= '0;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        cap_q[i] <= '0;
      end
    end else begin
      in_frame_q <= in_frame_d;
      idx_q      <= idx_d;
      open_q     <= open_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      acc_q      <= acc_d;
      flen_q     <= flen_d;
      cap_q      <= cap_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result assembly: values past the captured count, or with no storage, read 0
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < OUT_VALUES; k++) begin : g_val
    if (k < NUM_FIELDS) begin : g_cap
      assign res_vals[k] = (IDX_W'(k) < idx_d) ? cap_d[k] : 32'd0;
    end else begin : g_zero
      assign res_vals[k] = 32'd0;
    end
  end

  assign push_data.values = res_vals;
  assign push_data.count  = (32'(idx_d) > 7) ? 3'd7 : CNT_W'(idx_d);

  bcsv_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .stat_o      (buf_stat)
  );

  assign value_0_o     = out_data.values[0];
  assign value_1_o     = out_data.values[1];
  assign value_2_o     = out_data.values[2];
  assign value_3_o     = out_data.values[3];
  assign field_count_o = out_data.count;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // skid entry only ever fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_stat.skid_valid |-> buf_stat.out_valid)
    else $error("skid valid without output valid");

  // a byte that closes a frame never meets a full result buffer
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_stat.out_valid && buf_stat.skid_valid && !out_fire) |-> !push)
    else $error("result pushed into full buffer");

  // frame length stays bounded and is cleared while hunting
  a_flen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flen_q <= FLEN_W'(MAX_FRAME)) && (in_frame_q || flen_q == '0))
    else $error("frame length out of range");

  // no stall when nothing is buffered or in flight
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!byte_v_q && !buf_stat.out_valid) |-> !in_stall_o)
    else $error("stall with empty pipeline");

endmodule

`default_nettype wire

>>> tb/sv/bracketed_csv_integer_frame_parser_top_tb.sv
module bracketed_csv_integer_frame_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcsv_pkg::*;

  // byte beats from '[' on that the random part aims for
  localparam int ITEM_TARGET    = 1300;
  // longest gap of the sender and longest stall of the receiver, per beat
  localparam int MAX_GAP        = 10;
  // cycles in a row with no beat on either side before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  // cycles run once every beat is taken and every closed frame seen
  localparam int DRAIN_CYCLES   = 8;
  // two to the 31st, the magnitude where the value saturates
  localparam longint unsigned MAG_CAP = 64'h8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        rx_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic signed [31:0] value_0_o;
  logic signed [31:0] value_1_o;
  logic signed [31:0] value_2_o;
  logic signed [31:0] value_3_o;
  logic [2:0]        field_count_o;

  bracketed_csv_integer_frame_parser_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_0_o     (value_0_o),
    .value_1_o     (value_1_o),
    .value_2_o     (value_2_o),
    .value_3_o     (value_3_o),
    .field_count_o (field_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // frame parser mirror: tracks hunting / collecting and the open token
  // ---------------------------------------------------------------------------
  logic        fr_open   = 1'b0;
  int unsigned fr_len    = 0;
  int unsigned tok_cnt   = 0;
  logic        tok_live  = 1'b0;
  phase_e      num_phase = PH_SPACE;
  logic        num_neg   = 1'b0;
  logic [31:0] num_mag   = '0;
  logic [31:0] tok_vals [NUM_FIELDS];

  // frames closed by ']' whose result has not come out yet, oldest first
  res_t parsed_frames [$];

  // commit the open token if there is still room for it
  function automatic void close_field();
    if (tok_live && tok_cnt < NUM_FIELDS) begin
      if (num_neg) begin
        tok_vals[tok_cnt] = 32'(0) - num_mag;
      end else begin
        tok_vals[tok_cnt] = (num_mag >= 32'(MAG_CAP)) ? 32'h7FFF_FFFF : num_mag;
      end
      tok_cnt++;
    end
    tok_live = 1'b0;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] c);
    res_t            frame;
    longint unsigned wide;
    if (!fr_open) begin
      // hunting: only '[' matters
      if (c == CH_LBRACK) begin
        fr_open   = 1'b1;
        fr_len    = 1;
        tok_cnt   = 0;
        tok_live  = 1'b0;
        num_phase = PH_SPACE;
        num_neg   = 1'b0;
        num_mag   = '0;
        foreach (tok_vals[i]) tok_vals[i] = '0;
      end
      return;
    end
    // the beat that would push the frame past its limit is swallowed
    if (fr_len >= MAX_FRAME) begin
      fr_open  = 1'b0;
      fr_len   = 0;
      tok_live = 1'b0;
      return;
    end
    fr_len++;
    if (c == CH_COMMA) begin
      close_field();
    end else if (c != CH_RBRACK) begin
      // token content: whitespace, sign, digits, then anything ends the number
      if (!tok_live) begin
        tok_live  = 1'b1;
        num_phase = PH_SPACE;
        num_neg   = 1'b0;
        num_mag   = '0;
      end
      if (tok_cnt < NUM_FIELDS && num_phase != PH_DONE) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          wide = 10 * longint'(num_mag) + longint'(c - CH_ZERO);
          num_mag   = (wide > MAG_CAP) ? 32'(MAG_CAP) : wide[31:0];
          num_phase = PH_DIGITS;
        end else if (num_phase == PH_SPACE &&
                     (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
          // still in leading whitespace
        end else if (num_phase == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
          num_neg   = (c == CH_MINUS);
          num_phase = PH_DIGITS;
        end else begin
          num_phase = PH_DONE;
        end
      end
    end else begin
      close_field();
      for (int k = 0; k < OUT_VALUES; k++) begin
        frame.values[k] = (k < NUM_FIELDS && k < tok_cnt) ? tok_vals[k] : '0;
      end
      frame.count = CNT_W'(tok_cnt > 7 ? 7 : tok_cnt);
      parsed_frames.push_back(frame);
      fr_open = 1'b0;
      fr_len  = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus store
  // ---------------------------------------------------------------------------
  logic [7:0] rx_pending [$];
  int         framed_bytes = 0;
  int         bytes_total  = 0;

  string big_nums [6] = '{"2147483647", "2147483648", "2147483649",
                          "4294967295", "4294967306", "99999999999"};
  string filler = "0123456789,+- x";

  task automatic put_byte(input logic [7:0] b);
    rx_pending.push_back(b);
    framed_bytes++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic add_random_frame();
    int kind;
    int ntok;
    // a little line noise ahead of the frame, ']' and '[' among it
    repeat ($urandom_range(0, 3)) rx_pending.push_back(8'($urandom_range(0, 255)));
    put_byte(CH_LBRACK);
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      // overlong: last beat lands right at the length limit or just past it
      repeat (MAX_FRAME - 2 + $urandom_range(0, 2)) begin
        put_byte(filler[$urandom_range(0, filler.len() - 1)]);
      end
      put_byte($urandom_range(0, 1) ? CH_RBRACK : CH_LBRACK);
    end else if (kind < 12) begin
      // garbage body, maybe closed
      repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) put_byte(CH_RBRACK);
    end else begin
      ntok = $urandom_range(0, 6);
      if ($urandom_range(0, 7) == 0) put_byte(CH_COMMA);
      for (int t = 0; t < ntok; t++) begin
        // separators, runs of commas now and then
        if (t > 0) begin
          put_byte(CH_COMMA);
          if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) put_byte(CH_COMMA);
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            put_byte(($urandom_range(0, 2) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
          end
        end
        case ($urandom_range(0, 5))
          0: put_byte(CH_PLUS);
          1: put_byte(CH_MINUS);
          default: ;
        endcase
        if ($urandom_range(0, 7) == 0) begin
          put_text(big_nums[$urandom_range(0, 5)]);
        end else begin
          repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : $urandom_range(1, 4)) begin
            put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
          end
        end
        // trailing junk, sometimes followed by more digits
        if ($urandom_range(0, 9) == 0) begin
          put_byte(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1) == 1) put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
      end
      if ($urandom_range(0, 7) == 0) put_byte(CH_COMMA);
      // now and then the frame is left open and the next '[' lands inside it
      if ($urandom_range(0, 19) != 0) put_byte(CH_RBRACK);
    end
  endtask

  // ---------------------------------------------------------------------------
  // handshake bookkeeping shared by driver and monitor
  // (written at the rising edge, read at the falling edge, or the other way)
  // ---------------------------------------------------------------------------
  logic       byte_taken = 1'b0;
  logic       res_taken  = 1'b0;
  logic       drv_valid  = 1'b0;
  logic [7:0] drv_byte   = '0;
  int         byte_gap   = 0;
  int         stall_left = 0;
  logic       in_calm    = 1'b0;
  logic       out_calm   = 1'b0;
  int         bytes_seen = 0;
  int         idle_cycles = 0;
  int         mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // driver: byte channel and result stall, both moved at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // beat taken last edge: draw the gap before the next one
      if (byte_taken) begin
        byte_taken = 1'b0;
        drv_valid  = 1'b0;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        byte_gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (!drv_valid && rx_pending.size() > 0) begin
        if (byte_gap > 0) begin
          byte_gap--;
        end else begin
          drv_valid = 1'b1;
          drv_byte  = rx_pending.pop_front();
        end
      end
      // payload is don't-care while idle, keep it moving
      if (!drv_valid) drv_byte = 8'($urandom_range(0, 255));
      in_valid_i <= drv_valid;
      rx_byte_i  <= drv_byte;
      // result taken last edge: draw how long the next one waits
      if (res_taken) begin
        res_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        stall_left = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  // monitor: feeds accepted bytes to the mirror and checks each result beat
  always @(posedge clk_i) begin : beat_mon
    res_t        want;
    logic [31:0] seen [OUT_VALUES];
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid_i && !in_stall_o) begin
        parse_rx_byte(rx_byte_i);
        bytes_seen++;
        byte_taken  = 1'b1;
        idle_cycles = 0;
      end
      // stall only runs down while a result is actually held back
      if (out_valid_o && out_stall_i && stall_left > 0) stall_left--;
      if (out_valid_o && !out_stall_i) begin
        res_taken   = 1'b1;
        idle_cycles = 0;
        seen = '{value_0_o, value_1_o, value_2_o, value_3_o};
        if (parsed_frames.size() == 0) begin
          report_mismatch($sformatf("result with no closed frame, count %0d", field_count_o));
        end else begin
          want = parsed_frames.pop_front();
          for (int k = 0; k < OUT_VALUES; k++) begin
            if (seen[k] !== want.values[k]) begin
              report_mismatch($sformatf("value_%0d got %0d want %0d", k,
                                        $signed(seen[k]), $signed(want.values[k])));
            end
          end
          if (field_count_o !== want.count) begin
            report_mismatch($sformatf("field_count got %0d want %0d",
                                      field_count_o, want.count));
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    out_stall_i = 1'b0;

    // directed: ']' while hunting, negative clamp, whitespace and sign,
    // runs of commas, junk token, bare sign, tokens past the fourth, empty frame
    rx_pending.push_back(CH_RBRACK);
    put_text("[-2147483649,\t+7,,z,-,9,1]");
    put_text("[]");
    rx_pending.push_back(8'h00);

    // random frames, mostly well formed
    while (framed_bytes < ITEM_TARGET) add_random_frame();
    bytes_total = rx_pending.size();
    stall_left  = $urandom_range(0, MAX_GAP);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every beat taken and every closed frame seen, then a short drain
    while (bytes_seen < bytes_total || parsed_frames.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
